### rtl/neighbor_table_replay_check_assert.svh
// Assertion macros shared by the neighbor table modules.
`ifndef NEIGHBOR_TABLE_REPLAY_CHECK_ASSERT_SVH
`define NEIGHBOR_TABLE_REPLAY_CHECK_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define NTRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define NTRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ntrc_pkg.sv
// Package with the types, constants and helpers of the neighbor table.
`timescale 1ns / 1ps

package ntrc_pkg;

  // Table geometry.
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int ID_W   = 48;
  localparam int SEQ_W  = 16;
  localparam int TIME_W = 32;
  localparam int OCNT_W = 5;

  // Request codes.
  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_EXPIRE = 2'd2;

  // Outcome codes.
  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_UPDATED = 2'd1;
  localparam logic [1:0] OUT_ADDED   = 2'd2;
  localparam logic [1:0] OUT_DROPPED = 2'd3;

  // Sequence wrap window and timeout after reset.
  localparam logic [SEQ_W-1:0]  SEQ_WRAP_HIGH = 16'd60000;
  localparam logic [SEQ_W-1:0]  SEQ_WRAP_LOW  = 16'd5000;
  localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd3000;

  // One stored neighbor.
  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [SEQ_W-1:0]  prev_seq;
    logic              seq_valid;
    logic [TIME_W-1:0] last_seen;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic hit_act;
    logic miss_act;
    logic sweep_step;
    logic sweep_done;
  } ntrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;
    logic cmp_valid;
    logic hit;
  } ntrc_sts_t;

  // A sequence is fresh if none is stored, it is newer, or it wrapped around.
  function automatic logic seq_fresh(input logic [SEQ_W-1:0] stored_seq,
                                     input logic seq_valid,
                                     input logic [SEQ_W-1:0] seq);
    return !seq_valid || (seq > stored_seq) ||
           ((stored_seq > SEQ_WRAP_HIGH) && (seq < SEQ_WRAP_LOW));
  endfunction

  // Reports a count on the five-bit result ports, keeping the low bits.
  function automatic logic [OCNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCNT_W-1:0] ext;
    ext = {{OCNT_W{1'b0}}, cnt};
    return ext[OCNT_W-1:0];
  endfunction

endpackage

### rtl/ntrc_ctrl.sv
// Controller state machine that sequences searches and expire sweeps.
`timescale 1ns / 1ps
`include "neighbor_table_replay_check_assert.svh"

module ntrc_ctrl
  import ntrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_req_type,
  input  ntrc_sts_t  sts,
  output ntrc_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_SWEEP  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   fin;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_req_type == REQ_EXPIRE) ? ST_SWEEP : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The first match ends the search; running out of entries is a miss.
        if (sts.hit) begin
          cmd.hit_act = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.more) begin
          cmd.issue = 1'b1;
        end else begin
          cmd.miss_act = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // Each fetched entry is kept or dropped in the cycle after its read.
        cmd.sweep_step = sts.cmp_valid;
        if (sts.more) begin
          cmd.issue = 1'b1;
        end else if (!sts.cmp_valid) begin
          cmd.sweep_done = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign fin  = cmd.hit_act | cmd.miss_act | cmd.sweep_done;

  `NTRC_ASSERT_NEXT(a_fin_to_idle, fin, state_r == ST_IDLE, "controller did not return to idle")
  `NTRC_ASSERT_NEXT(a_load_busy, cmd.load, busy, "accepted request did not raise busy")

endmodule

### rtl/ntrc_datapath.sv
// Datapath with the entry memory, request registers, counters and result registers.
`timescale 1ns / 1ps
`include "neighbor_table_replay_check_assert.svh"

module ntrc_datapath
  import ntrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ntrc_cmd_t         cmd,
  output ntrc_sts_t         sts,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  input  logic [1:0]        in_req_type,
  input  logic [ID_W-1:0]   in_node_id,
  input  logic [SEQ_W-1:0]  in_seq_num,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_strobe,
  output logic              out_seq_ok,
  output logic [1:0]        out_outcome,
  output logic [OCNT_W-1:0] out_entry_count,
  output logic [OCNT_W-1:0] out_removed_count
);

  // Entry memory.
  entry_t mem [DEPTH];

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  // Control registers.
  logic [TIME_W-1:0] timeout_r, timeout_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic              strobe_r, strobe_nxt;

  // Request and work registers.
  logic [1:0]        req_type_r, req_type_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]  wr_cnt_r, wr_cnt_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  entry_t            rd_data_r;

  // Result registers.
  logic              seq_ok_r, seq_ok_nxt;
  logic [1:0]        outcome_r, outcome_nxt;
  logic [OCNT_W-1:0] ecount_r, ecount_nxt;
  logic [OCNT_W-1:0] rcount_r, rcount_nxt;

  logic [TIME_W-1:0] age;
  logic              keep;
  logic              full;

  // Status toward the controller.
  assign sts.more      = (rd_cnt_r < count_r);
  assign sts.cmp_valid = cmp_valid_r;
  assign sts.hit       = cmp_valid_r && (rd_data_r.node_id == id_r);

  // Modular age of the fetched entry against the timeout.
  assign age  = now_r - rd_data_r.last_seen;
  assign keep = (age < timeout_r);
  assign full = (count_r == CNT_W'(DEPTH));

  // Next-state logic for all registers and the memory write port.
  always_comb begin
    timeout_nxt   = timeout_r;
    count_nxt     = count_r;
    cmp_valid_nxt = cmd.issue;
    strobe_nxt    = 1'b0;
    req_type_nxt  = req_type_r;
    id_nxt        = id_r;
    seq_nxt       = seq_r;
    now_nxt       = now_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    removed_nxt   = removed_r;
    cmp_idx_nxt   = cmp_idx_r;
    seq_ok_nxt    = seq_ok_r;
    outcome_nxt   = outcome_r;
    ecount_nxt    = ecount_r;
    rcount_nxt    = rcount_r;
    mem_we        = 1'b0;
    mem_waddr     = cmp_idx_r;
    mem_wdata     = rd_data_r;

    if (cfg_wr_en) begin
      timeout_nxt = cfg_wr_data;
    end

    // Capture a new request.
    if (cmd.load) begin
      req_type_nxt = in_req_type;
      id_nxt       = in_node_id;
      seq_nxt      = in_seq_num;
      now_nxt      = in_now_ms;
      rd_cnt_nxt   = '0;
      wr_cnt_nxt   = '0;
      removed_nxt  = '0;
    end

    // Fetch the next entry in table order.
    if (cmd.issue) begin
      rd_cnt_nxt  = rd_cnt_r + 1'b1;
      cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
    end

    // Expire sweep: survivors move down to the write pointer.
    if (cmd.sweep_step) begin
      if (keep) begin
        mem_we     = 1'b1;
        mem_waddr  = wr_cnt_r[IDX_W-1:0];
        mem_wdata  = rd_data_r;
        wr_cnt_nxt = wr_cnt_r + 1'b1;
      end else begin
        removed_nxt = removed_r + 1'b1;
      end
    end

    // Default result fields for a finishing request.
    if (cmd.hit_act || cmd.miss_act || cmd.sweep_done) begin
      strobe_nxt  = 1'b1;
      seq_ok_nxt  = 1'b0;
      outcome_nxt = OUT_NONE;
      ecount_nxt  = cnt_to_out(count_r);
      rcount_nxt  = '0;
    end

    // Matching entry: judge the sequence or refresh the entry.
    if (cmd.hit_act) begin
      if (req_type_r == REQ_CHECK) begin
        seq_ok_nxt = seq_fresh(rd_data_r.prev_seq, rd_data_r.seq_valid, seq_r);
      end else if (req_type_r == REQ_UPDATE) begin
        mem_we              = 1'b1;
        mem_waddr           = cmp_idx_r;
        mem_wdata.node_id   = id_r;
        mem_wdata.prev_seq  = seq_r;
        mem_wdata.seq_valid = 1'b1;
        mem_wdata.last_seen = now_r;
        outcome_nxt         = OUT_UPDATED;
      end
    end

    // Unknown node: accept a check, append or drop an update.
    if (cmd.miss_act) begin
      if (req_type_r == REQ_CHECK) begin
        seq_ok_nxt = 1'b1;
      end else if (req_type_r == REQ_UPDATE) begin
        if (full) begin
          outcome_nxt = OUT_DROPPED;
        end else begin
          mem_we              = 1'b1;
          mem_waddr           = count_r[IDX_W-1:0];
          mem_wdata.node_id   = id_r;
          mem_wdata.prev_seq  = seq_r;
          mem_wdata.seq_valid = 1'b1;
          mem_wdata.last_seen = now_r;
          count_nxt           = count_r + 1'b1;
          outcome_nxt         = OUT_ADDED;
          ecount_nxt          = cnt_to_out(count_nxt);
        end
      end
    end

    // End of a sweep: the survivors form the new table.
    if (cmd.sweep_done) begin
      count_nxt  = wr_cnt_r;
      ecount_nxt = cnt_to_out(wr_cnt_r);
      rcount_nxt = cnt_to_out(removed_r);
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_cnt_r[IDX_W-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  // Request, work and result registers.
  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    id_r       <= id_nxt;
    seq_r      <= seq_nxt;
    now_r      <= now_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    wr_cnt_r   <= wr_cnt_nxt;
    removed_r  <= removed_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    seq_ok_r   <= seq_ok_nxt;
    outcome_r  <= outcome_nxt;
    ecount_r   <= ecount_nxt;
    rcount_r   <= rcount_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_seq_ok        = seq_ok_r;
  assign out_outcome       = outcome_r;
  assign out_entry_count   = ecount_r;
  assign out_removed_count = rcount_r;

  `NTRC_ASSERT_IMPL(a_count_max, 1'b1, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `NTRC_ASSERT_IMPL(a_sweep_order, cmd.sweep_step, wr_cnt_r <= CNT_W'(cmp_idx_r), "sweep write ahead")
  `NTRC_ASSERT_IMPL(a_sweep_total, cmd.sweep_done, (CNT_W+1)'(wr_cnt_r) + (CNT_W+1)'(removed_r) == (CNT_W+1)'(count_r), "sweep lost entries")

endmodule

### rtl/neighbor_table_replay_check.sv
// Top level of the neighbor table with sequence replay check.
//
//   Channel   Ports                                       Handshake
//   request   in_req_type in_node_id in_seq_num in_now_ms start high while busy low
//   result    out_seq_ok out_outcome out_entry_count ...  out_strobe, one cycle
//   config    cfg_wr_data                                 cfg_wr_en, one cycle
//
// A request is served by a linear scan of the entry memory, which reads one
// entry per cycle through its single read port; the read data and the result
// are registered. A check or update stops at the first matching entry; a
// sweep visits all entries. Reset clears the entry count and sets the
// timeout to 3000 ms; no clearing pass is needed. The result receiver cannot
// stall the block.
`timescale 1ns / 1ps

module neighbor_table_replay_check
  import ntrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [ID_W-1:0]   in_node_id,
  input  logic [SEQ_W-1:0]  in_seq_num,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_strobe,
  output logic              out_seq_ok,
  output logic [1:0]        out_outcome,
  output logic [OCNT_W-1:0] out_entry_count,
  output logic [OCNT_W-1:0] out_removed_count,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  ntrc_cmd_t cmd;
  ntrc_sts_t sts;

  // Sequencer.
  ntrc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // Table storage and arithmetic.
  ntrc_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_node_id        (in_node_id),
    .in_seq_num        (in_seq_num),
    .in_now_ms         (in_now_ms),
    .out_strobe        (out_strobe),
    .out_seq_ok        (out_seq_ok),
    .out_outcome       (out_outcome),
    .out_entry_count   (out_entry_count),
    .out_removed_count (out_removed_count)
  );

endmodule
